FILE: src/jcws_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package jcws_pkg;

   localparam int SecW  = 23;   // 2^32-1 ms / 1000 fits in 23 bits
   localparam int IvW   = 16;
   localparam int SlotW = 17;
   localparam int RatW  = 24;   // product of three 8-bit divisors
   localparam int HashW = 32;
   localparam int MixW  = 8;

   localparam int FIFO_DEPTH    = 4;
   localparam int PRE_PAUSE_DEF = 5;

   // x / 1000 == (x * RECIP_1000) >> 38 for every 32-bit x
   localparam logic [28:0] RECIP_1000 = 29'h10624DD3;

   localparam logic [IvW-1:0]   DEF_IV      = 16'd60;
   localparam logic [IvW-1:0]   DEF_WIN     = 16'd10;
   localparam logic [IvW-1:0]   ALWAYS_LEFT = 16'd3600;
   localparam logic [HashW-1:0] HASH_K1     = 32'h7feb352d;
   localparam logic [HashW-1:0] HASH_K2     = 32'h846ca68b;

   localparam logic [1:0] MODE_ALWAYS = 2'd0;
   localparam logic [1:0] MODE_START  = 2'd1;

   typedef enum logic [2:0] {
      CSR_MODE  = 3'd0,
      CSR_IV    = 3'd1,
      CSR_WIN   = 3'd2,
      CSR_SEED  = 3'd3,
      CSR_MIXP  = 3'd4,
      CSR_MIXD  = 3'd5,
      CSR_EVEND = 3'd6,
      CSR_QUADD = 3'd7
   } csr_idx_type;

   typedef struct packed {
      logic [1:0]      mode;
      logic [IvW-1:0]  iv_len;
      logic [IvW-1:0]  win_len;
      logic [31:0]     seed;
      logic [MixW-1:0] mix_period;
      logic [MixW-1:0] mix_div;
      logic [MixW-1:0] even_div;
      logic [MixW-1:0] quad_div;
   } cfg_type;

   typedef struct packed {
      logic            alw;
      logic [SecW-1:0] sec;
   } item_type;

   function automatic logic [HashW-1:0] hash_fold(input logic [HashW-1:0] v,
                                                  input int sh);
      return v ^ (v >> sh);
   endfunction

   // window length of one interval, before start offset
   function automatic logic [IvW-1:0] eff_win(
      input logic [IvW-1:0] fw,
      input logic [IvW-1:0] iv,
      input logic           keep,
      input logic           ev_on,
      input logic           qd_on,
      input logic [1:0]     lsb,
      input logic [IvW-1:0] q_m,
      input logic [IvW-1:0] q_me,
      input logic [IvW-1:0] q_mq,
      input logic [IvW-1:0] q_meq);
      logic           e;
      logic           q;
      logic [IvW-1:0] w;
      e = ev_on && !lsb[0];
      q = qd_on && (lsb == 2'b00);
      if (keep) begin
         w = fw;
      end else begin
         case ({e, q})
            2'b11:   w = q_meq;
            2'b10:   w = q_me;
            2'b01:   w = q_mq;
            default: w = q_m;
         endcase
         if (w < 16'd2) begin
            w = 16'd2;
         end
      end
      if (w > iv) begin
         w = iv;
      end
      return w;
   endfunction

endpackage
`default_nettype wire

FILE: src/jcws_div.sv
`timescale 1ns / 1ps
`default_nettype none
// restoring divider, one quotient bit per stage, NW stages
module jcws_div import jcws_pkg::*; #(
   parameter int NW = 23,
   parameter int DW = 16
) (
   input  wire logic          clock,
   input  wire logic          en,
   input  wire logic [NW-1:0] dividend,
   input  wire logic [DW-1:0] divisor,
   output logic      [NW-1:0] quotient,
   output logic      [DW-1:0] remainder
);

   logic [DW-1:0] rem_ff [NW];
   logic [NW-1:0] quo_ff [NW];
   logic [NW-1:0] dvd_ff [NW];
   logic [DW-1:0] dvs_ff [NW];

   for (genvar g = 0; g < NW; g++) begin : g_stage
      logic [DW-1:0] rem_prev;
      logic [NW-1:0] quo_prev;
      logic [NW-1:0] dvd_prev;
      logic [DW-1:0] dvs_prev;
      logic [DW:0]   trial;
      logic          ge;
      logic [DW-1:0] rem_in;
      logic [NW-1:0] quo_in;

      if (g == 0) begin : g_first
         assign rem_prev = '0;
         assign quo_prev = '0;
         assign dvd_prev = dividend;
         assign dvs_prev = divisor;
      end else begin : g_next
         assign rem_prev = rem_ff[g-1];
         assign quo_prev = quo_ff[g-1];
         assign dvd_prev = dvd_ff[g-1];
         assign dvs_prev = dvs_ff[g-1];
      end

      assign trial  = {rem_prev, dvd_prev[NW-1-g]};
      assign ge     = trial >= {1'b0, dvs_prev};
      assign rem_in = ge ? DW'(trial - {1'b0, dvs_prev}) : trial[DW-1:0];
      assign quo_in = {quo_prev[NW-2:0], ge};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g] <= rem_in;
            quo_ff[g] <= quo_in;
            dvd_ff[g] <= dvd_prev;
            dvs_ff[g] <= dvs_prev;
         end
      end
   end

   assign quotient  = quo_ff[NW-1];
   assign remainder = rem_ff[NW-1];

endmodule
`default_nettype wire

FILE: src/jcws_dly.sv
`timescale 1ns / 1ps
`default_nettype none
module jcws_dly import jcws_pkg::*; #(
   parameter int W = 2,
   parameter int N = 4
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         en,
   input  wire logic [W-1:0] d,
   output logic      [W-1:0] q
);

   logic [W-1:0] sr_ff [N];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) begin
            sr_ff[i] <= '0;
         end
      end else if (en) begin
         sr_ff[0] <= d;
         for (int i = 1; i < N; i++) begin
            sr_ff[i] <= sr_ff[i-1];
         end
      end
   end

   assign q = sr_ff[N-1];

endmodule
`default_nettype wire

FILE: src/jcws_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module jcws_fifo import jcws_pkg::*; #(
   parameter int DEPTH = FIFO_DEPTH
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type din,
   output logic          full,
   input  wire logic     pop,
   output item_type      dout,
   output logic          empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   item_type        mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   cnt_ff, cnt_in;

   assign full  = cnt_ff == CW'(DEPTH);
   assign empty = cnt_ff == '0;
   assign dout  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule
`default_nettype wire

FILE: src/jcws_front.sv
`timescale 1ns / 1ps
`default_nettype none
// takes the beat, marks always-mode items and converts ms to s
module jcws_front import jcws_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [1:0]  mode,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_now_ms,
   output logic             push,
   output item_type         item,
   input  wire logic        full
);

   logic        vld_ff, vld_in;
   logic [31:0] now_ff;
   logic        accept;
   logic [60:0] prod;

   assign req_stall = vld_ff && full;
   assign accept    = req_valid && !req_stall;
   assign push      = vld_ff && !full;
   assign vld_in    = accept || (vld_ff && full);

   assign prod     = 61'(now_ff) * 61'(RECIP_1000);
   assign item.sec = prod[60:38];
   assign item.alw = mode == MODE_ALWAYS;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         now_ff <= req_now_ms;
      end
   end

endmodule
`default_nettype wire

FILE: src/jcws_back.sv
`timescale 1ns / 1ps
`default_nettype none
// bucket/phase divide, mix remainder and window divides, hash, slot modulo, compare
module jcws_back import jcws_pkg::*; #(
   parameter int PRE_PAUSE_SEC = PRE_PAUSE_DEF
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   input  wire logic     in_valid,
   input  wire item_type in_item,
   output logic          in_pop,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   output logic          rsp_active,
   output logic          rsp_prep_active,
   output logic [15:0]   rsp_seconds_left,
   output logic [16:0]   rsp_seconds_until
);

   localparam int S2W = 2 + SecW + IvW;
   localparam int S3W = 2 + 3 * IvW;

   logic             adv;
   logic [IvW-1:0]   iv, fw, mw;
   logic [SlotW-1:0] slot_mod;
   logic             mix_en, ev_on, qd_on;
   logic [15:0]      me_ff, mq_ff;
   logic [RatW-1:0]  meq_ff;

   assign adv      = !rsp_valid || !rsp_stall;
   assign in_pop   = adv && in_valid;
   assign iv       = (cfg.iv_len == '0) ? DEF_IV : cfg.iv_len;
   assign fw       = (cfg.win_len == '0) ? DEF_WIN : cfg.win_len;
   assign mw       = (fw > iv) ? iv : fw;
   assign slot_mod = SlotW'(iv) - SlotW'(mw) + 1'b1;
   assign mix_en   = (cfg.mix_period >= 8'd2) && (cfg.mix_div >= 8'd2);
   assign ev_on    = cfg.even_div >= 8'd2;
   assign qd_on    = cfg.quad_div >= 8'd2;

   // divisor products, config-only
   always_ff @(posedge clock) begin
      me_ff  <= {8'b0, cfg.mix_div} * {8'b0, cfg.even_div};
      mq_ff  <= {8'b0, cfg.mix_div} * {8'b0, cfg.quad_div};
      meq_ff <= {8'b0, me_ff} * {16'b0, cfg.quad_div};
   end

   // bucket and phase
   logic [SecW-1:0] bucket_a;
   logic [IvW-1:0]  phase_a;
   logic [1:0]      s1;

   jcws_div #(.NW(SecW), .DW(IvW)) u_div_iv (
      .clock(clock), .en(adv), .dividend(in_item.sec), .divisor(iv),
      .quotient(bucket_a), .remainder(phase_a));

   jcws_dly #(.W(2), .N(SecW)) u_dly_1 (
      .clock(clock), .reset(reset), .en(adv),
      .d({in_pop, in_item.alw}), .q(s1));

   // mix remainder and shortened windows
   logic [MixW-1:0] r_b;
   logic [SecW-1:0] qm_full, qme_full, qmq_full, qmeq_full;
   logic [RatW-1:0] unused_m, unused_me, unused_mq, unused_meq;
   logic [S2W-1:0]  s2;
   logic [SecW-1:0] fw_x;
   logic [SecW-1:0] unused_b;

   assign fw_x = SecW'(fw);

   jcws_div #(.NW(SecW), .DW(MixW)) u_div_mix (
      .clock(clock), .en(adv), .dividend(bucket_a), .divisor(cfg.mix_period),
      .quotient(unused_b), .remainder(r_b));

   jcws_div #(.NW(SecW), .DW(RatW)) u_div_wm (
      .clock(clock), .en(adv), .dividend(fw_x), .divisor(RatW'(cfg.mix_div)),
      .quotient(qm_full), .remainder(unused_m));
   jcws_div #(.NW(SecW), .DW(RatW)) u_div_wme (
      .clock(clock), .en(adv), .dividend(fw_x), .divisor(RatW'(me_ff)),
      .quotient(qme_full), .remainder(unused_me));
   jcws_div #(.NW(SecW), .DW(RatW)) u_div_wmq (
      .clock(clock), .en(adv), .dividend(fw_x), .divisor(RatW'(mq_ff)),
      .quotient(qmq_full), .remainder(unused_mq));
   jcws_div #(.NW(SecW), .DW(RatW)) u_div_wmeq (
      .clock(clock), .en(adv), .dividend(fw_x), .divisor(meq_ff),
      .quotient(qmeq_full), .remainder(unused_meq));

   jcws_dly #(.W(S2W), .N(SecW)) u_dly_2 (
      .clock(clock), .reset(reset), .en(adv),
      .d({s1, bucket_a, phase_a}), .q(s2));

   logic             v2, alw2;
   logic [SecW-1:0]  bucket_b, bucket_n;
   logic [IvW-1:0]   phase_b;
   logic [MixW-1:0]  r_n;
   logic             last_b;
   logic [IvW-1:0]   w0_in, w1_in;
   logic [HashW-1:0] x0, x1;

   assign {v2, alw2, bucket_b, phase_b} = s2;
   assign bucket_n = bucket_b + 1'b1;
   assign last_b   = r_b == (cfg.mix_period - 1'b1);
   assign r_n      = last_b ? '0 : r_b + 1'b1;
   assign x0       = HashW'(bucket_b) ^ cfg.seed;
   assign x1       = HashW'(bucket_n) ^ cfg.seed;

   assign w0_in = eff_win(fw, iv, !mix_en || last_b, ev_on, qd_on, bucket_b[1:0],
                          qm_full[IvW-1:0], qme_full[IvW-1:0], qmq_full[IvW-1:0],
                          qmeq_full[IvW-1:0]);
   assign w1_in = eff_win(fw, iv, !mix_en || (r_n == (cfg.mix_period - 1'b1)),
                          ev_on, qd_on, bucket_n[1:0],
                          qm_full[IvW-1:0], qme_full[IvW-1:0], qmq_full[IvW-1:0],
                          qmeq_full[IvW-1:0]);

   // two hash rounds
   logic [1:0]       ctl3_ff, ctl4_ff;
   logic [IvW-1:0]   ph3_ff, ph4_ff, w03_ff, w04_ff, w13_ff, w14_ff;
   logic [HashW-1:0] pa_ff, pb_ff, qa_ff, qb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl3_ff <= '0;
         ctl4_ff <= '0;
      end else if (adv) begin
         ctl3_ff <= {v2, alw2};
         ctl4_ff <= ctl3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ph3_ff <= phase_b;
         w03_ff <= w0_in;
         w13_ff <= w1_in;
         pa_ff  <= HashW'(hash_fold(x0, 16) * HASH_K1);
         pb_ff  <= HashW'(hash_fold(x1, 16) * HASH_K1);
         ph4_ff <= ph3_ff;
         w04_ff <= w03_ff;
         w14_ff <= w13_ff;
         qa_ff  <= HashW'(hash_fold(pa_ff, 15) * HASH_K2);
         qb_ff  <= HashW'(hash_fold(pb_ff, 15) * HASH_K2);
      end
   end

   // slot offsets for this and the next interval
   logic [SlotW-1:0] slot0, slot1;
   logic [HashW-1:0] unused_h0, unused_h1;
   logic [S3W-1:0]   s5;

   jcws_div #(.NW(HashW), .DW(SlotW)) u_div_s0 (
      .clock(clock), .en(adv), .dividend(hash_fold(qa_ff, 16)), .divisor(slot_mod),
      .quotient(unused_h0), .remainder(slot0));
   jcws_div #(.NW(HashW), .DW(SlotW)) u_div_s1 (
      .clock(clock), .en(adv), .dividend(hash_fold(qb_ff, 16)), .divisor(slot_mod),
      .quotient(unused_h1), .remainder(slot1));

   jcws_dly #(.W(S3W), .N(HashW)) u_dly_3 (
      .clock(clock), .reset(reset), .en(adv),
      .d({ctl4_ff, ph4_ff, w04_ff, w14_ff}), .q(s5));

   logic             v5, alw5;
   logic [IvW-1:0]   ph5, w05, w15;
   logic [SlotW-1:0] st0, st1, end0, until_in;
   logic [15:0]      left_in;
   logic             act_in, prep_in;

   assign {v5, alw5, ph5, w05, w15} = s5;
   assign st0  = (cfg.mode == MODE_START) ? '0 : slot0;
   assign st1  = (cfg.mode == MODE_START) ? '0 : slot1;
   assign end0 = st0 + SlotW'(w05);

   always_comb begin
      act_in   = 1'b0;
      left_in  = '0;
      until_in = '0;
      if ((SlotW'(ph5) >= st0) && (SlotW'(ph5) < end0)) begin
         act_in  = 1'b1;
         left_in = 16'(end0 - SlotW'(ph5));
      end else if (SlotW'(ph5) < st0) begin
         until_in = st0 - SlotW'(ph5);
      end else begin
         until_in = SlotW'(iv) - SlotW'(ph5) + st1;
      end
      prep_in = !act_in && (until_in != '0) && (until_in <= SlotW'(PRE_PAUSE_SEC));
      if (alw5) begin
         act_in   = 1'b1;
         prep_in  = 1'b0;
         left_in  = ALWAYS_LEFT;
         until_in = '0;
      end
   end

   logic rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= v5;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_active        <= act_in;
         rsp_prep_active   <= prep_in;
         rsp_seconds_left  <= left_in;
         rsp_seconds_until <= until_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/jittered_capture_window_scheduler_core.sv
// Throughput: one beat per cycle while rsp is not stalled; the back pipeline (three chains
// of one-bit-per-stage dividers and two hash multiplies) advances whenever the rsp
// register can move.
// A four-entry queue sits between the front converter and the back pipeline.
// Reset (synchronous) clears all configuration registers to zero and empties the pipeline.
`timescale 1ns / 1ps
`default_nettype none
module jittered_capture_window_scheduler_core import jcws_pkg::*; #(
   parameter int PRE_PAUSE_SEC = PRE_PAUSE_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_now_ms,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_active,
   output logic             rsp_prep_active,
   output logic [15:0]      rsp_seconds_left,
   output logic [16:0]      rsp_seconds_until
);

   cfg_type  cfg_ff;
   logic     push, full, pop, empty;
   item_type f_item, q_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_MODE:  cfg_ff.mode       <= csr_wdata[1:0];
            CSR_IV:    cfg_ff.iv_len     <= csr_wdata[15:0];
            CSR_WIN:   cfg_ff.win_len    <= csr_wdata[15:0];
            CSR_SEED:  cfg_ff.seed       <= csr_wdata;
            CSR_MIXP:  cfg_ff.mix_period <= csr_wdata[7:0];
            CSR_MIXD:  cfg_ff.mix_div    <= csr_wdata[7:0];
            CSR_EVEND: cfg_ff.even_div   <= csr_wdata[7:0];
            CSR_QUADD: cfg_ff.quad_div   <= csr_wdata[7:0];
            default:   cfg_ff            <= cfg_ff;
         endcase
      end
   end

   jcws_front u_front (
      .clock(clock), .reset(reset), .mode(cfg_ff.mode),
      .req_valid(req_valid), .req_stall(req_stall), .req_now_ms(req_now_ms),
      .push(push), .item(f_item), .full(full));

   jcws_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
      .clock(clock), .reset(reset), .push(push), .din(f_item), .full(full),
      .pop(pop), .dout(q_item), .empty(empty));

   jcws_back #(.PRE_PAUSE_SEC(PRE_PAUSE_SEC)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .in_valid(!empty), .in_item(q_item), .in_pop(pop),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_active(rsp_active), .rsp_prep_active(rsp_prep_active),
      .rsp_seconds_left(rsp_seconds_left), .rsp_seconds_until(rsp_seconds_until));

endmodule
`default_nettype wire
